// File: hdl/ptd_pkg.sv
// Shared types and constants for the periodic task dispatcher.
package ptd_pkg;

  localparam int SLOTS_DEF   = 8;
  localparam int MAX_RESULTS = 8;
  localparam int CNT_W       = 4;
  localparam int TIME_W      = 32;
  localparam int SLOT_W      = 3;
  localparam int OUT_DATA_W  = 40;

  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_ADD  = 2'd1,
    KIND_RUN  = 2'd2,
    KIND_NOP  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    OUT_ACCEPTED = 2'd0,
    OUT_REFUSED  = 2'd1,
    OUT_FIRED    = 2'd2,
    OUT_NONE     = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_DONE = 2'd2
  } state_t;

  typedef struct packed {
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] last_run;
  } slot_entry_t;

endpackage

// File: hdl/periodic_task_dispatcher_unit.sv
// Periodic task dispatcher: slot table in a synchronous memory, scanned one slot a cycle.
//
//  channel | dir | handshake              | payload
//  in_     | in  | in_tvalid / in_tready  | tuser kind, tdata period
//  out_    | out | out_tvalid / out_tready| tuser outcome, tdata slot + now_ms, tlast
//
// A tick is taken in IDLE; an add is accepted in IDLE, then DONE loads the result into the
// output register. A run scans in SCAN, then ends in DONE: the memory read port delivers one
// slot per cycle unless stalled, and the scan ends early once MAX_RESULTS slots have fired.
// A firing stalls the scan only while an earlier firing is held back and the output register
// is still full.
// Reset clears the valid bits, the counter and the control state; the memory needs no clear,
// since only valid slots, which have been written, are ever used.
module periodic_task_dispatcher_unit #(
  parameter int SLOTS = ptd_pkg::SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [ptd_pkg::TIME_W-1:0]     in_tdata,   // [31:0] period
  input  logic [1:0]                     in_tuser,   // [1:0] kind
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [ptd_pkg::OUT_DATA_W-1:0] out_tdata,  // [2:0] slot, [34:3] now_ms, zero fill
  output logic [1:0]                     out_tuser,  // [1:0] outcome
  output logic                           out_tlast
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);
  localparam logic [ptd_pkg::CNT_W-1:0] CNT_LAST = ptd_pkg::CNT_W'(ptd_pkg::MAX_RESULTS - 1);

  // slot table
  ptd_pkg::slot_entry_t mem [SLOTS];
  ptd_pkg::slot_entry_t rdata_r;
  logic [IDX_W-1:0]     raddr;
  logic                 mem_we;
  logic [IDX_W-1:0]     waddr;
  ptd_pkg::slot_entry_t wdata;

  ptd_pkg::state_t state_r, state_nxt;
  logic [SLOTS-1:0]               valid_r;
  logic [ptd_pkg::TIME_W-1:0]     millis_r;
  logic [IDX_W-1:0]               idx_r;
  logic [ptd_pkg::CNT_W-1:0]      cnt_r;
  logic                           hold_v_r;
  ptd_pkg::outcome_t              hold_outcome_r;
  logic [IDX_W-1:0]               hold_slot_r;

  logic                           out_valid_r;
  ptd_pkg::outcome_t              out_outcome_r;
  logic [ptd_pkg::SLOT_W-1:0]     out_slot_r;
  logic                           out_last_r;
  logic [ptd_pkg::TIME_W-1:0]     out_now_r;

  logic                           in_xfer;
  ptd_pkg::kind_t                 in_kind;
  logic                           out_free;
  logic                           full;
  logic [IDX_W-1:0]               free_idx;
  logic                           cur_valid;
  logic [ptd_pkg::TIME_W-1:0]     elapsed;
  logic                           one_shot;
  logic                           due;
  logic                           stall;
  logic                           adv;
  logic                           end_scan;
  logic                           out_load;
  ptd_pkg::outcome_t              out_outcome_nxt;
  logic [IDX_W-1:0]               out_idx_nxt;
  logic                           out_last_nxt;
  logic [IDX_W+2:0]               out_idx_ext;

  assign in_kind   = ptd_pkg::kind_t'(in_tuser);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign full      = &valid_r;

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) free_idx = IDX_W'(i);
    end
  end

  assign cur_valid = valid_r[idx_r];
  assign elapsed   = millis_r - rdata_r.last_run;
  assign one_shot  = (rdata_r.period == '0);
  assign due       = cur_valid && (one_shot || (elapsed >= rdata_r.period));
  // a second firing needs the output register to take the one held back
  assign stall     = due && hold_v_r && !out_free;
  assign adv       = (state_r == ptd_pkg::ST_SCAN) && !stall;
  assign end_scan  = adv && ((idx_r == IDX_LAST) || (due && (cnt_r == CNT_LAST)));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ptd_pkg::ST_IDLE: begin
        if (in_xfer && (in_kind == ptd_pkg::KIND_ADD || in_kind == ptd_pkg::KIND_RUN)) begin
          state_nxt = (in_kind == ptd_pkg::KIND_RUN) ? ptd_pkg::ST_SCAN : ptd_pkg::ST_DONE;
        end
      end
      ptd_pkg::ST_SCAN: begin
        if (end_scan) state_nxt = ptd_pkg::ST_DONE;
      end
      ptd_pkg::ST_DONE: begin
        if (out_free) state_nxt = ptd_pkg::ST_IDLE;
      end
      default: state_nxt = ptd_pkg::ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_tready       = 1'b0;
    out_load        = 1'b0;
    out_outcome_nxt = ptd_pkg::OUT_NONE;
    out_idx_nxt     = '0;
    out_last_nxt    = 1'b1;
    mem_we          = 1'b0;
    waddr           = idx_r;
    wdata.period    = rdata_r.period;
    wdata.last_run  = millis_r;
    raddr           = idx_r;
    unique case (state_r)
      ptd_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        raddr     = '0;
        if (in_xfer && in_kind == ptd_pkg::KIND_ADD && !full) begin
          mem_we       = 1'b1;
          waddr        = free_idx;
          wdata.period = in_tdata;
        end
      end
      ptd_pkg::ST_SCAN: begin
        if (adv && idx_r != IDX_LAST) raddr = idx_r + 1'b1;
        if (adv && due && !one_shot) mem_we = 1'b1;
        if (adv && due && hold_v_r) begin
          out_load        = 1'b1;
          out_outcome_nxt = ptd_pkg::OUT_FIRED;
          out_idx_nxt     = hold_slot_r;
          out_last_nxt    = 1'b0;
        end
      end
      ptd_pkg::ST_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          if (hold_v_r) begin
            out_outcome_nxt = hold_outcome_r;
            out_idx_nxt     = hold_slot_r;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ptd_pkg::ST_IDLE;
      valid_r  <= '0;
      millis_r <= '0;
      idx_r    <= '0;
      cnt_r    <= '0;
      hold_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_xfer) begin
        case (in_kind)
          ptd_pkg::KIND_TICK: millis_r <= millis_r + 1'b1;
          ptd_pkg::KIND_ADD: begin
            hold_v_r <= 1'b1;
            if (full) begin
              hold_outcome_r <= ptd_pkg::OUT_REFUSED;
              hold_slot_r    <= '0;
            end else begin
              hold_outcome_r    <= ptd_pkg::OUT_ACCEPTED;
              hold_slot_r       <= free_idx;
              valid_r[free_idx] <= 1'b1;
            end
          end
          ptd_pkg::KIND_RUN: begin
            hold_v_r <= 1'b0;
            idx_r    <= '0;
            cnt_r    <= '0;
          end
          default: ;
        endcase
      end
      if (adv) begin
        if (idx_r != IDX_LAST) idx_r <= idx_r + 1'b1;
        if (due) begin
          hold_v_r       <= 1'b1;
          hold_outcome_r <= ptd_pkg::OUT_FIRED;
          hold_slot_r    <= idx_r;
          cnt_r          <= cnt_r + 1'b1;
          if (one_shot) valid_r[idx_r] <= 1'b0;
        end
      end
    end
  end

  assign out_idx_ext = {3'b000, out_idx_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_outcome_r <= out_outcome_nxt;
      out_slot_r    <= out_idx_ext[2:0];
      out_last_r    <= out_last_nxt;
      out_now_r     <= millis_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_outcome_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {5'b00000, out_now_r, out_slot_r};

  // firings per run stay within the result limit
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= ptd_pkg::CNT_W'(ptd_pkg::MAX_RESULTS))
    else $error("firing count over limit");

  // scan writes back only slots that are live
  a_scan_write_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ptd_pkg::ST_SCAN && mem_we) |-> cur_valid)
    else $error("scan wrote a free slot");

  // the closing result of an input goes out with last set
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ptd_pkg::ST_DONE && out_free) |=>
      (state_r == ptd_pkg::ST_IDLE && out_valid_r && out_last_r))
    else $error("closing result missing last");

  // an accepted add claims exactly one slot
  a_add_claims: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_kind == ptd_pkg::KIND_ADD && !full) |=>
      ($countones(valid_r) == $past($countones(valid_r)) + 1))
    else $error("add did not claim a slot");

endmodule
